>>> rtl/core/swcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swcr_pkg;

  // width of the image size and byte count
  localparam int SIZE_BITS = 24;

  // the sum of a byte count and a frame length, one bit of headroom
  localparam int SUM_BITS = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 1;

  // configuration register file
  localparam int NUM_REGS  = 3;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_EXPECTED_SIZE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_START_OFFSET  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = REG_IDX_W'(2);

  localparam logic [SIZE_BITS-1:0] EXPECTED_SIZE_RST = SIZE_BITS'(1);
  localparam logic [SIZE_BITS-1:0] START_OFFSET_RST  = '0;
  localparam logic [15:0]          TIMEOUT_TICKS_RST = 16'd30;

  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_FRAME      = 3'd1,
    MODE_CRC_ERR    = 3'd2,
    MODE_TOO_LARGE  = 3'd3,
    MODE_DISCONNECT = 3'd4,
    MODE_TICK       = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ACK_OK         = 3'd0,
    ACK_BAD_SEQ    = 3'd1,
    ACK_OVER_SIZE  = 3'd2,
    ACK_WRITE_FAIL = 3'd3,
    ACK_CRC        = 3'd4,
    ACK_TOO_LARGE  = 3'd5
  } ack_code_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECV   = 2'd1,
    PH_STAGED = 2'd2,
    PH_ERROR  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [SIZE_BITS-1:0] expected_size;
    logic [SIZE_BITS-1:0] start_offset;
    logic [15:0]          timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e               phase;
    logic [SIZE_BITS-1:0] byte_count;
    logic [15:0]          next_seq;
    logic [15:0]          quiet_ticks;
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] frame_seq;
    logic [15:0] frame_length;
    logic        write_ok;
  } item_t;

  typedef struct packed {
    logic                 ack_valid;
    logic [15:0]          ack_seq;
    logic [2:0]           ack_code;
    logic                 commit_payload;
    logic [1:0]           session_state;
    logic [SIZE_BITS-1:0] received_bytes;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/swcr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// event request channel
interface swcr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] frame_seq;
  logic [15:0] frame_length;
  logic        write_ok;

  modport source (output valid, output mode, output frame_seq, output frame_length,
                  output write_ok, input ready);
  modport sink   (input valid, input mode, input frame_seq, input frame_length,
                  input write_ok, output ready);
endinterface

// result request channel
interface swcr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ack_valid;
  logic [15:0]                    ack_seq;
  logic [2:0]                     ack_code;
  logic                           commit_payload;
  logic [1:0]                     session_state;
  logic [swcr_pkg::SIZE_BITS-1:0] received_bytes;

  modport source (output valid, output ack_valid, output ack_seq, output ack_code,
                  output commit_payload, output session_state, output received_bytes,
                  input ready);
  modport sink   (input valid, input ack_valid, input ack_seq, input ack_code,
                  input commit_payload, input session_state, input received_bytes,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/stop_and_wait_chunk_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Receiver side of a stop-and-wait image transfer. Each event request (start, frame, crc
// error, oversize frame, disconnect, tick) gives exactly one result request carrying the
// optional acknowledgement, the commit flag, the session state and the byte count. One
// event is taken every clock cycle while the result side is not stalled. Each event passes
// through the event register and then the result register, with the whole classification
// and state update done combinationally between them. A stalled result holds the event
// register, so a second event waits while both are full. Configuration (size, resume
// offset, timeout) is to be written by the user over the APB port while no events are in
// flight; the block itself does not enforce this. Registers sit at byte addresses 0, 4
// and 8.
module stop_and_wait_chunk_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swcr_in_if.sink                       in_i,
  swcr_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swcr_pkg::PADDR_W-1:0]  paddr,
  input  logic [swcr_pkg::PDATA_W-1:0]  pwdata,
  output logic [swcr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  swcr_pkg::cfg_t    cfg;
  swcr_pkg::state_t  state_q;
  swcr_pkg::state_t  state_d;
  swcr_pkg::state_t  step_state;
  swcr_pkg::item_t   item_q;
  swcr_pkg::item_t   item_d;
  swcr_pkg::result_t step_res;
  swcr_pkg::result_t res_q;
  swcr_pkg::result_t res_d;
  logic              in_valid_q;
  logic              in_valid_d;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              in_take;
  logic              fire;

  swcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swcr_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // handshake: process when the result register is free or being drained
  assign fire     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | fire;
  assign in_take  = in_i.valid & in_i.ready;

  // event register
  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (in_take) begin
      in_valid_d          = 1'b1;
      item_d.mode         = in_i.mode;
      item_d.frame_seq    = in_i.frame_seq;
      item_d.frame_length = in_i.frame_length;
      item_d.write_ok     = in_i.write_ok;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // session state and result register
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      state_d     = step_state;
      res_d       = step_res;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.phase       <= swcr_pkg::PH_IDLE;
      state_q.byte_count  <= '0;
      state_q.next_seq    <= '0;
      state_q.quiet_ticks <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.ack_valid      = res_q.ack_valid;
  assign out_o.ack_seq        = res_q.ack_seq;
  assign out_o.ack_code       = res_q.ack_code;
  assign out_o.commit_payload = res_q.commit_payload;
  assign out_o.session_state  = res_q.session_state;
  assign out_o.received_bytes = res_q.received_bytes;

endmodule

`default_nettype wire

>>> rtl/core/swcr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module swcr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swcr_pkg::PADDR_W-1:0]  paddr,
  input  logic [swcr_pkg::PDATA_W-1:0]  pwdata,
  output logic [swcr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output swcr_pkg::cfg_t                cfg_o
);

  logic [swcr_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;
  swcr_pkg::cfg_t                 cfg_q;
  swcr_pkg::cfg_t                 cfg_d;

  assign pready = 1'b1;
  assign idx    = paddr[swcr_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        swcr_pkg::REG_EXPECTED_SIZE: begin
          cfg_d.expected_size = pwdata[swcr_pkg::SIZE_BITS-1:0];
        end
        swcr_pkg::REG_START_OFFSET: begin
          cfg_d.start_offset = pwdata[swcr_pkg::SIZE_BITS-1:0];
        end
        swcr_pkg::REG_TIMEOUT_TICKS: begin
          cfg_d.timeout_ticks = pwdata[15:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_size <= swcr_pkg::EXPECTED_SIZE_RST;
      cfg_q.start_offset  <= swcr_pkg::START_OFFSET_RST;
      cfg_q.timeout_ticks <= swcr_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      swcr_pkg::REG_EXPECTED_SIZE: begin
        prdata = swcr_pkg::PDATA_W'(cfg_q.expected_size);
      end
      swcr_pkg::REG_START_OFFSET: begin
        prdata = swcr_pkg::PDATA_W'(cfg_q.start_offset);
      end
      swcr_pkg::REG_TIMEOUT_TICKS: begin
        prdata = swcr_pkg::PDATA_W'(cfg_q.timeout_ticks);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/swcr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module swcr_step (
  input  swcr_pkg::cfg_t    cfg_i,
  input  swcr_pkg::state_t  state_i,
  input  swcr_pkg::item_t   item_i,
  output swcr_pkg::state_t  state_o,
  output swcr_pkg::result_t result_o
);

  logic [swcr_pkg::SIZE_BITS-1:0] resume_off;
  logic [swcr_pkg::SUM_BITS-1:0]  sum;
  logic [swcr_pkg::SUM_BITS-1:0]  size_ext;
  logic [15:0]                    prev_seq;
  logic [15:0]                    ticks_inc;
  logic                           receiving;

  // resume offset falls back to zero when beyond the size
  assign resume_off = (cfg_i.start_offset <= cfg_i.expected_size) ? cfg_i.start_offset : '0;

  assign sum       = swcr_pkg::SUM_BITS'(state_i.byte_count) +
                     swcr_pkg::SUM_BITS'(item_i.frame_length);
  assign size_ext  = swcr_pkg::SUM_BITS'(cfg_i.expected_size);
  assign prev_seq  = state_i.next_seq - 16'd1;
  assign ticks_inc = (state_i.quiet_ticks != 16'hFFFF) ? state_i.quiet_ticks + 16'd1
                                                       : state_i.quiet_ticks;
  assign receiving = (state_i.phase == swcr_pkg::PH_RECV);

  // event classification and state update
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (swcr_pkg::mode_e'(item_i.mode))
      swcr_pkg::MODE_START: begin
        if (!receiving && cfg_i.expected_size != '0) begin
          if (resume_off == cfg_i.expected_size) begin
            state_o.byte_count = cfg_i.expected_size;
            state_o.phase      = swcr_pkg::PH_STAGED;
          end else begin
            state_o.byte_count  = resume_off;
            state_o.next_seq    = '0;
            state_o.quiet_ticks = '0;
            state_o.phase       = swcr_pkg::PH_RECV;
          end
        end
      end
      swcr_pkg::MODE_FRAME: begin
        if (receiving) begin
          state_o.quiet_ticks = '0;
          result_o.ack_valid  = 1'b1;
          result_o.ack_seq    = item_i.frame_seq;
          result_o.ack_code   = swcr_pkg::ACK_OK;
          if (item_i.frame_length == '0) begin
            // end of stream
            state_o.phase = (state_i.byte_count >= cfg_i.expected_size) ?
                            swcr_pkg::PH_STAGED : swcr_pkg::PH_IDLE;
          end else if (item_i.frame_seq == prev_seq) begin
            // duplicate, re-ack only
            result_o.ack_code = swcr_pkg::ACK_OK;
          end else if (item_i.frame_seq != state_i.next_seq) begin
            result_o.ack_code = swcr_pkg::ACK_BAD_SEQ;
            state_o.phase     = swcr_pkg::PH_ERROR;
          end else if (sum > size_ext) begin
            result_o.ack_code = swcr_pkg::ACK_OVER_SIZE;
            state_o.phase     = swcr_pkg::PH_ERROR;
          end else if (!item_i.write_ok) begin
            result_o.ack_code = swcr_pkg::ACK_WRITE_FAIL;
            state_o.phase     = swcr_pkg::PH_ERROR;
          end else begin
            state_o.byte_count      = sum[swcr_pkg::SIZE_BITS-1:0];
            state_o.next_seq        = state_i.next_seq + 16'd1;
            result_o.commit_payload = 1'b1;
            state_o.phase = (sum >= size_ext) ? swcr_pkg::PH_STAGED : swcr_pkg::PH_RECV;
          end
        end
      end
      swcr_pkg::MODE_CRC_ERR: begin
        if (receiving) begin
          result_o.ack_valid = 1'b1;
          result_o.ack_seq   = item_i.frame_seq;
          result_o.ack_code  = swcr_pkg::ACK_CRC;
          state_o.phase      = swcr_pkg::PH_ERROR;
        end
      end
      swcr_pkg::MODE_TOO_LARGE: begin
        if (receiving) begin
          result_o.ack_valid = 1'b1;
          result_o.ack_seq   = '0;
          result_o.ack_code  = swcr_pkg::ACK_TOO_LARGE;
          state_o.phase      = swcr_pkg::PH_ERROR;
        end
      end
      swcr_pkg::MODE_DISCONNECT: begin
        if (receiving) begin
          state_o.phase = swcr_pkg::PH_IDLE;
        end
      end
      swcr_pkg::MODE_TICK: begin
        if (receiving) begin
          state_o.quiet_ticks = ticks_inc;
          if (ticks_inc > cfg_i.timeout_ticks) begin
            state_o.phase = swcr_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.session_state  = state_o.phase;
    result_o.received_bytes = state_o.byte_count;
  end

endmodule

`default_nettype wire

>>> rtl/core/swcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module swcr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           ack_valid_i,
  input logic [15:0]                    ack_seq_i,
  input logic [2:0]                     ack_code_i,
  input logic                           commit_payload_i,
  input logic [1:0]                     session_state_i,
  input logic [swcr_pkg::SIZE_BITS-1:0] received_bytes_i
);

  // no ack means empty ack fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ack_valid_i |-> ack_code_i == 3'(swcr_pkg::ACK_OK) && ack_seq_i == '0)
    else $error("ack fields set without ack");

  // a committed payload is always acked as ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && commit_payload_i |-> ack_valid_i && ack_code_i == 3'(swcr_pkg::ACK_OK))
    else $error("commit without ok ack");

  // an error ack always leaves the session in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ack_valid_i && ack_code_i != 3'(swcr_pkg::ACK_OK) |->
      session_state_i == 2'(swcr_pkg::PH_ERROR))
    else $error("error ack without error state");

  // oversize frame acks carry sequence zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ack_valid_i && ack_code_i == 3'(swcr_pkg::ACK_TOO_LARGE) |->
      ack_seq_i == '0)
    else $error("too large ack with nonzero sequence");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(received_bytes_i) &&
      $stable(session_state_i) && $stable(ack_seq_i))
    else $error("stalled result changed");

endmodule

bind stop_and_wait_chunk_receiver_top swcr_checker u_swcr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .ack_valid_i      (out_o.ack_valid),
  .ack_seq_i        (out_o.ack_seq),
  .ack_code_i       (out_o.ack_code),
  .commit_payload_i (out_o.commit_payload),
  .session_state_i  (out_o.session_state),
  .received_bytes_i (out_o.received_bytes)
);

`default_nettype wire

>>> test/tb_stop_and_wait_chunk_receiver_top.sv
`timescale 1ns / 1ps

module tb_stop_and_wait_chunk_receiver_top;
  import swcr_pkg::*;

  localparam int unsigned TOTAL_EVENTS     = 1750;
  localparam int unsigned QUIET_TIMEOUT    = 50;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned MAX_IDLE         = 11;
  localparam int unsigned REPORT_LIMIT     = 10;

  // encodings the block must ignore
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  // session model: classifies each accepted event and keeps the results it owes
  class receiver_scoreboard;
    cfg_t                 cfg;
    phase_e               phase;
    logic [SIZE_BITS-1:0] byte_count;
    logic [15:0]          next_seq;
    logic [15:0]          quiet_ticks;
    result_t              results_due[$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          commits;
    int unsigned          error_acks;

    function new();
      cfg.expected_size = EXPECTED_SIZE_RST;
      cfg.start_offset  = START_OFFSET_RST;
      cfg.timeout_ticks = TIMEOUT_TICKS_RST;
      phase       = PH_IDLE;
      byte_count  = '0;
      next_seq    = '0;
      quiet_ticks = '0;
      mismatches  = 0;
      checked     = 0;
      commits     = 0;
      error_acks  = 0;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_EXPECTED_SIZE: cfg.expected_size = value[SIZE_BITS-1:0];
        REG_START_OFFSET:  cfg.start_offset  = value[SIZE_BITS-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks = value[15:0];
        default: ;
      endcase
    endfunction

    // one event always owes exactly one result
    function void note_request(item_t ev);
      result_t              r;
      logic [SIZE_BITS:0]   total;
      logic [SIZE_BITS-1:0] offset;
      r     = '0;
      total = {1'b0, byte_count} + (SIZE_BITS + 1)'(ev.frame_length);
      if (ev.mode == MODE_START) begin
        // start is refused while receiving or with a zero size
        if (phase != PH_RECV && cfg.expected_size != '0) begin
          offset = (cfg.start_offset <= cfg.expected_size) ? cfg.start_offset : '0;
          if (offset == cfg.expected_size) begin
            byte_count = cfg.expected_size;
            phase      = PH_STAGED;
          end else begin
            byte_count  = offset;
            next_seq    = '0;
            quiet_ticks = '0;
            phase       = PH_RECV;
          end
        end
      end else if (phase == PH_RECV) begin
        case (ev.mode)
          MODE_FRAME: begin
            quiet_ticks = '0;
            r.ack_valid = 1'b1;
            r.ack_seq   = ev.frame_seq;
            if (ev.frame_length == '0) begin
              // end of stream
              r.ack_code = ACK_OK;
              phase = (byte_count >= cfg.expected_size) ? PH_STAGED : PH_IDLE;
            end else if (ev.frame_seq == 16'(next_seq - 16'd1)) begin
              // repeat of the last acked frame, acked again
              r.ack_code = ACK_OK;
            end else if (ev.frame_seq != next_seq) begin
              r.ack_code = ACK_BAD_SEQ;
              phase      = PH_ERROR;
            end else if (total > {1'b0, cfg.expected_size}) begin
              r.ack_code = ACK_OVER_SIZE;
              phase      = PH_ERROR;
            end else if (!ev.write_ok) begin
              r.ack_code = ACK_WRITE_FAIL;
              phase      = PH_ERROR;
            end else begin
              byte_count       = total[SIZE_BITS-1:0];
              next_seq         = next_seq + 16'd1;
              r.commit_payload = 1'b1;
              r.ack_code       = ACK_OK;
              phase = (byte_count >= cfg.expected_size) ? PH_STAGED : PH_RECV;
            end
          end
          MODE_CRC_ERR: begin
            r.ack_valid = 1'b1;
            r.ack_seq   = ev.frame_seq;
            r.ack_code  = ACK_CRC;
            phase       = PH_ERROR;
          end
          MODE_TOO_LARGE: begin
            r.ack_valid = 1'b1;
            r.ack_code  = ACK_TOO_LARGE;
            phase       = PH_ERROR;
          end
          MODE_DISCONNECT: phase = PH_IDLE;
          MODE_TICK: begin
            if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
            if (quiet_ticks > cfg.timeout_ticks) phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      r.session_state  = phase;
      r.received_bytes = byte_count;
      if (r.commit_payload) commits++;
      if (r.ack_valid && r.ack_code != ACK_OK) error_acks++;
      results_due.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with nothing outstanding: ack %0b seq %h code %0d state %0d bytes %0d",
                   got.ack_valid, got.ack_seq, got.ack_code, got.session_state,
                   got.received_bytes);
        return;
      end
      want = results_due.pop_front();
      checked++;
      if (got.ack_valid !== want.ack_valid || got.ack_seq !== want.ack_seq ||
          got.ack_code !== want.ack_code || got.commit_payload !== want.commit_payload ||
          got.session_state !== want.session_state ||
          got.received_bytes !== want.received_bytes) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d expected: ack %0b seq %h code %0d commit %0b state %0d bytes %0d",
                   checked, want.ack_valid, want.ack_seq, want.ack_code, want.commit_payload,
                   want.session_state, want.received_bytes);
          $display("result %0d actual:   ack %0b seq %h code %0d commit %0b state %0d bytes %0d",
                   checked, got.ack_valid, got.ack_seq, got.ack_code, got.commit_payload,
                   got.session_state, got.received_bytes);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  swcr_in_if  ev_if ();
  swcr_out_if res_if ();

  receiver_scoreboard sb;

  bit          calm_events;
  bit          calm_results;
  int unsigned cycle_count;
  int unsigned events_sent;
  int unsigned live_events;
  int unsigned reg_writes;

  stop_and_wait_chunk_receiver_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stop_and_wait_chunk_receiver_top test failed");
      $finish;
    end
  end

  // watch both channels; results are checked before the same edge's event is noted
  always @(posedge clk_i) begin : monitor
    item_t   seen;
    result_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.ack_valid      = res_if.ack_valid;
        got.ack_seq        = res_if.ack_seq;
        got.ack_code       = res_if.ack_code;
        got.commit_payload = res_if.commit_payload;
        got.session_state  = res_if.session_state;
        got.received_bytes = res_if.received_bytes;
        sb.check_result(got);
      end
      if (ev_if.valid && ev_if.ready) begin
        seen.mode         = ev_if.mode;
        seen.frame_seq    = ev_if.frame_seq;
        seen.frame_length = ev_if.frame_length;
        seen.write_ok     = ev_if.write_ok;
        sb.note_request(seen);
      end
    end
  end

  // result side: random stall before taking each result
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm_results ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // random gap before the next event request
  task automatic idle_gap();
    int unsigned gap;
    gap = calm_events ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk_i);
    if (gap != 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic present(item_t ev);
    ev_if.valid        <= 1'b1;
    ev_if.mode         <= ev.mode;
    ev_if.frame_seq    <= ev.frame_seq;
    ev_if.frame_length <= ev.frame_length;
    ev_if.write_ok     <= ev.write_ok;
    do @(posedge clk_i); while (!ev_if.ready);
    events_sent++;
  endtask

  task automatic send(logic [2:0] mode, logic [15:0] seq, logic [15:0] len, logic wok);
    item_t ev;
    ev.mode         = mode;
    ev.frame_seq    = seq;
    ev.frame_length = len;
    ev.write_ok     = wok;
    idle_gap();
    present(ev);
  endtask

  // hold events back until every owed result is in
  task automatic settle();
    @(negedge clk_i);
    ev_if.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
    reg_writes++;
  endtask

  // fresh size, resume offset and timeout, upper data bits as noise
  task automatic random_settings();
    logic [SIZE_BITS-1:0] new_size;
    logic [SIZE_BITS-1:0] new_offset;
    logic [15:0]          new_ticks;
    int unsigned          pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       new_size = '0;
    else if (pick < 15) new_size = SIZE_BITS'(1);
    else if (pick < 65) new_size = SIZE_BITS'($urandom_range(1, 64));
    else if (pick < 90) new_size = SIZE_BITS'($urandom_range(65, 4000));
    else                new_size = SIZE_BITS'($urandom_range(4001, (1 << SIZE_BITS) - 1));
    pick = $urandom_range(0, 99);
    if (pick < 50)      new_offset = '0;
    else if (pick < 70) new_offset = SIZE_BITS'($urandom_range(0, new_size));
    else if (pick < 85) new_offset = new_size;
    else if (pick < 95) new_offset = SIZE_BITS'($urandom());
    else if (new_size == '1) new_offset = '1;
    else new_offset = SIZE_BITS'($urandom_range(new_size + 1, (1 << SIZE_BITS) - 1));
    pick = $urandom_range(0, 99);
    if (pick < 60)      new_ticks = 16'($urandom_range(1, 12));
    else if (pick < 90) new_ticks = 16'($urandom_range(13, 200));
    else if (pick < 95) new_ticks = 16'hFFFF;
    else                new_ticks = 16'($urandom());
    settle();
    write_register(REG_EXPECTED_SIZE, PDATA_W'({$urandom(), new_size}));
    write_register(REG_START_OFFSET, PDATA_W'({$urandom(), new_offset}));
    write_register(REG_TIMEOUT_TICKS, PDATA_W'({$urandom(), new_ticks}));
  endtask

  // mostly well-formed traffic shaped from the current session state
  function automatic item_t shape_event();
    item_t                ev;
    int unsigned          pick;
    int unsigned          lim;
    logic [SIZE_BITS-1:0] room;
    ev.mode         = MODE_FRAME;
    ev.frame_seq    = sb.next_seq;
    ev.frame_length = 16'($urandom());
    ev.write_ok     = 1'($urandom());
    pick = $urandom_range(0, 99);
    if (sb.phase != PH_RECV) begin
      if (pick < 80) ev.mode = MODE_START;
      else begin
        ev.mode      = 3'($urandom_range(1, 7));
        ev.frame_seq = 16'($urandom());
      end
      return ev;
    end
    room = (sb.cfg.expected_size > sb.byte_count) ? sb.cfg.expected_size - sb.byte_count : '0;
    lim  = (room > 24'd65535) ? 65535 : int'(room);
    if (pick < 72 || pick >= 93 || pick == 84) begin
      // in-order frame that fits, or a failed write of one
      if (lim == 0) ev.frame_length = '0;
      else if ($urandom_range(0, 1) == 0) ev.frame_length = 16'($urandom_range(1, lim));
      else ev.frame_length = 16'($urandom_range(1, (lim + 7) / 8));
      ev.write_ok = (pick != 84);
    end else if (pick < 76) begin
      ev.frame_seq    = sb.next_seq - 16'd1;
      ev.frame_length = 16'($urandom_range(1, 65535));
    end else if (pick < 82) begin
      ev.mode = MODE_TICK;
    end else if (pick == 82) begin
      ev.frame_seq    = 16'($urandom());
      ev.frame_length = 16'($urandom_range(1, 65535));
    end else if (pick == 83) begin
      ev.frame_length = (lim == 65535) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(lim + 1, 65535));
    end else if (pick == 85) begin
      ev.mode      = MODE_CRC_ERR;
      ev.frame_seq = 16'($urandom());
    end else if (pick == 86) begin
      ev.mode = MODE_TOO_LARGE;
    end else if (pick == 87) begin
      ev.mode = MODE_DISCONNECT;
    end else if (pick == 88) begin
      ev.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
    end else if (pick == 89) begin
      ev.mode = MODE_START;
    end else begin
      // end of stream
      ev.frame_length = '0;
      if ($urandom_range(0, 1) == 0) ev.frame_seq = 16'($urandom());
    end
    return ev;
  endfunction

  initial begin
    int unsigned steps;
    bit          was_live;
    sb = new();
    calm_events        = 1'b0;
    calm_results       = 1'b0;
    cycle_count        = 0;
    events_sent        = 0;
    live_events        = 0;
    reg_writes         = 0;
    ev_if.valid        = 1'b0;
    ev_if.mode         = MODE_START;
    ev_if.frame_seq    = '0;
    ev_if.frame_length = '0;
    ev_if.write_ok     = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: idle events ignored, start, repeated start, wrapped duplicate
    send(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'hFFFF, 16'h0001, 1'b0);
    send(MODE_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1);
    send(MODE_SPARE_7, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'h0001, 1'b1);

    // largest size, resume one full frame short of it, a timeout of one tick
    settle();
    write_register(REG_EXPECTED_SIZE, PDATA_W'(24'hFFFFFF));
    write_register(REG_START_OFFSET, PDATA_W'(24'hFF0000));
    write_register(REG_TIMEOUT_TICKS, PDATA_W'(16'd1));
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'hFFFF, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    send(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'hFFFF, 1'b1);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0005, 16'h0003, 1'b1);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_CRC_ERR, 16'hFFFF, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_TOO_LARGE, 16'h1234, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_DISCONNECT, 16'h0000, 16'h0000, 1'b0);

    // a frame whose sum runs past the byte count width
    settle();
    write_register(REG_START_OFFSET, PDATA_W'(24'hFFFFFA));
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'hFFFF, 1'b1);

    // resume at the full size goes straight to staged
    settle();
    write_register(REG_START_OFFSET, PDATA_W'(24'hFFFFFF));
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);

    // zero size refuses start
    settle();
    write_register(REG_EXPECTED_SIZE, '0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);

    // offset above size counts as zero; size shrunk mid-transfer stages on end of stream
    settle();
    write_register(REG_EXPECTED_SIZE, PDATA_W'(24'd100));
    write_register(REG_START_OFFSET, PDATA_W'(24'd200));
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'd60, 1'b1);
    settle();
    write_register(REG_EXPECTED_SIZE, PDATA_W'(24'd40));
    send(MODE_FRAME, 16'h0001, 16'h0000, 1'b0);
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'd10, 1'b1);
    send(MODE_FRAME, 16'h0001, 16'h0000, 1'b1);

    // ticks up to the timeout keep the session, a frame clears them, one more drops it
    settle();
    write_register(REG_EXPECTED_SIZE, PDATA_W'(24'd1000));
    write_register(REG_START_OFFSET, '0);
    write_register(REG_TIMEOUT_TICKS, PDATA_W'(QUIET_TIMEOUT));
    calm_events  = 1'b1;
    calm_results = 1'b1;
    send(MODE_START, 16'h0000, 16'h0000, 1'b0);
    repeat (QUIET_TIMEOUT) send(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    send(MODE_FRAME, 16'h0000, 16'd10, 1'b1);
    repeat (QUIET_TIMEOUT + 1) send(MODE_TICK, 16'h0000, 16'h0000, 1'b0);

    // random sessions
    while (events_sent < TOTAL_EVENTS) begin
      if ($urandom_range(0, 3) == 0) random_settings();
      else if ($urandom_range(0, 5) == 0) settle();
      calm_events  = ($urandom_range(0, 4) == 0);
      calm_results = ($urandom_range(0, 4) == 0);
      steps = $urandom_range(4, 40);
      repeat (steps) begin
        idle_gap();
        was_live = (sb.phase == PH_RECV);
        present(shape_event());
        if (was_live) live_events++;
      end
    end

    // drain and let the pipeline empty
    settle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d events accepted, %0d of them inside a live session, %0d results checked",
             events_sent, live_events, sb.checked);
    $display("%0d payloads committed, %0d error acknowledgements, %0d register writes",
             sb.commits, sb.error_acks, reg_writes);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("stop_and_wait_chunk_receiver_top test passed");
    end else begin
      $display("%0d mismatches, %0d results still owed", sb.mismatches, sb.results_due.size());
      $display("stop_and_wait_chunk_receiver_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/swcr_pkg.sv
rtl/core/swcr_if.sv
rtl/core/swcr_regs.sv
rtl/core/swcr_step.sv
rtl/core/stop_and_wait_chunk_receiver_top.sv
rtl/core/swcr_checker.sv
test/tb_stop_and_wait_chunk_receiver_top.sv
